/* hw/rtl/bmp_pkg.sv */
// Shared types, codes and helpers for the BMP pixel-array unpacker.
package bmp_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned PALETTE_DEPTH_DEF = 256;

  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 13;
  localparam int unsigned DIM_W = 13;
  localparam int unsigned POS_W = 12;

  localparam logic [CFG_AW-1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [1:0] FMT_PAL8 = 2'd0;
  localparam logic [1:0] FMT_BGR24 = 2'd1;
  localparam logic [1:0] FMT_BGRA32 = 2'd2;

  localparam logic CMD_PAL_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [1:0]       pixel_format;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } bmp_cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
    logic [7:0] data_byte;
  } bmp_in_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [POS_W-1:0] pixel_x;
    logic [POS_W-1:0] pixel_y;
    logic             last_pixel;
  } bmp_out_t;

  // Zero counts as one, anything above MAX_DIM as MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if ({{(32-DIM_W){1'b0}}, v} > 32'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v;
  endfunction

endpackage

/* hw/rtl/bmp_pixel_to_rgba.sv */
// Top level of the BMP pixel-array to RGBA unpacker.
// An accepted byte that completes a pixel shows on the output register in the next cycle.
// Throughput: one item per cycle; in_stall_o follows a held, stalled result.
// Palette lookups use a single registered read port, timed with the result.
// Reset clears counters, byte phase, padding state and output valid; the
// registers return to 24-bit BGR, 1 x 1. Palette contents are not cleared.
module bmp_pixel_to_rgba
  import bmp_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bmp_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bmp_out_t          out_data_o
);

  localparam int unsigned PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  bmp_cfg_t    cfg;
  logic        in_acc;
  logic        pal_we, pal_re;
  logic [23:0] pal_rdata;

  assign in_stall_o = out_valid_o && out_stall_i;
  assign in_acc = in_valid_i && !in_stall_o;

  assign pal_we = in_acc && (in_data_i.cmd == CMD_PAL_WRITE) &&
                  ({1'b0, in_data_i.palette_index} < 9'(PALETTE_DEPTH));
  assign pal_re = in_acc && (in_data_i.cmd == CMD_PIXEL);

  bmp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  bmp_palette #(
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .waddr_i(in_data_i.palette_index[PAL_AW-1:0]),
    .wdata_i({in_data_i.palette_red, in_data_i.palette_green, in_data_i.palette_blue}),
    .re_i   (pal_re),
    .raddr_i(in_data_i.data_byte[PAL_AW-1:0]),
    .rdata_o(pal_rdata)
  );

  bmp_unpack #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_unpack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_acc_i   (in_acc),
    .in_data_i  (in_data_i),
    .pal_rdata_i(pal_rdata),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule

/* hw/rtl/bmp_cfg_regs.sv */
// Configuration registers: pixel format and image dimensions.
module bmp_cfg_regs
  import bmp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  output bmp_cfg_t          cfg_o
);

  bmp_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PIXEL_FORMAT: cfg_d.pixel_format = cfg_wdata_i[1:0];
        CFG_IMAGE_WIDTH:  cfg_d.image_width = cfg_wdata_i;
        CFG_IMAGE_HEIGHT: cfg_d.image_height = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format <= FMT_BGR24;
      cfg_q.image_width <= DIM_W'(1);
      cfg_q.image_height <= DIM_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/bmp_palette.sv */
// Palette memory: one write port, one registered read port.
module bmp_palette #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [23:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [23:0]   rdata_o
);

  logic [23:0] mem [DEPTH];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bmp_unpack.sv */
// Byte assembly, row/column counters, padding skip and the result register.
module bmp_unpack
  import bmp_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bmp_cfg_t    cfg_i,
  input  logic        in_acc_i,
  input  bmp_in_t     in_data_i,
  input  logic [23:0] pal_rdata_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output bmp_out_t    out_data_o
);

  logic [1:0]       phase_q, phase_d;
  logic [23:0]      held_q, held_d;
  logic [POS_W-1:0] col_q, col_d;
  logic [POS_W-1:0] row_q, row_d;
  logic [1:0]       pad_q, pad_d;
  logic             in_pad_q, in_pad_d;
  logic             out_valid_q, out_valid_d;

  bmp_out_t res_q, res_d;
  logic     use_pal_q, pal_oor_q;

  logic [DIM_W-1:0] w, h, wm1, hm1;
  logic             row_end, img_end, emit;
  logic [1:0]       pad_len;
  logic [7:0]       d;

  assign d = in_data_i.data_byte;

  always_comb begin
    w = clamp_dim(cfg_i.image_width);
    h = clamp_dim(cfg_i.image_height);
    wm1 = w - DIM_W'(1);
    hm1 = h - DIM_W'(1);
    row_end = {1'b0, col_q} >= wm1;
    img_end = row_end && ({1'b0, row_q} >= hm1);
    // pad bytes per row, up to a multiple of 4; bytes per pixel mod 4 are 1, 3 or 0
    case (cfg_i.pixel_format)
      FMT_PAL8:  pad_len = 2'(-w[1:0]);
      FMT_BGR24: pad_len = w[1:0];
      default:   pad_len = 2'd0;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    held_d = held_q;
    col_d = col_q;
    row_d = row_q;
    pad_d = pad_q;
    in_pad_d = in_pad_q;
    emit = 1'b0;

    res_d = res_q;
    res_d.pixel_x = col_q;
    res_d.pixel_y = hm1[POS_W-1:0] - row_q;
    res_d.last_pixel = img_end;
    res_d.alpha = ALPHA_OPAQUE;

    if (in_acc_i && in_data_i.cmd == CMD_PIXEL) begin
      if (in_pad_q) begin
        pad_d = pad_q - 2'd1;
        if (pad_d == 2'd0) in_pad_d = 1'b0;
      end else begin
        case (cfg_i.pixel_format)
          FMT_PAL8: begin
            emit = 1'b1;
          end
          FMT_BGR24: begin
            if (phase_q >= 2'd2) begin
              emit = 1'b1;
              res_d.red = d;
              res_d.green = held_q[15:8];
              res_d.blue = held_q[7:0];
            end
          end
          default: begin
            if (phase_q == 2'd3) begin
              emit = 1'b1;
              res_d.red = held_q[23:16];
              res_d.green = held_q[15:8];
              res_d.blue = held_q[7:0];
              res_d.alpha = d;
            end
          end
        endcase

        if (emit) begin
          phase_d = 2'd0;
          held_d = '0;
          if (row_end) begin
            col_d = '0;
            row_d = img_end ? '0 : row_q + POS_W'(1);
            if (pad_len != 2'd0) begin
              in_pad_d = 1'b1;
              pad_d = pad_len;
            end
          end else begin
            col_d = col_q + POS_W'(1);
          end
        end else begin
          case (phase_q)
            2'd0:    held_d[7:0] = d;
            2'd1:    held_d[15:8] = d;
            2'd2:    held_d[23:16] = d;
            default: ;
          endcase
          phase_d = phase_q + 2'd1;
        end
      end
    end

    out_valid_d = (out_valid_q && out_stall_i) || emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      held_q <= '0;
      col_q <= '0;
      row_q <= '0;
      pad_q <= '0;
      in_pad_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      held_q <= held_d;
      col_q <= col_d;
      row_q <= row_d;
      pad_q <= pad_d;
      in_pad_q <= in_pad_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
      use_pal_q <= (cfg_i.pixel_format == FMT_PAL8);
      pal_oor_q <= ({1'b0, d} >= 9'(PALETTE_DEPTH));
    end
  end

  // palette data arrives registered alongside the result
  always_comb begin
    out_data_o = res_q;
    if (use_pal_q) begin
      out_data_o.red = pal_oor_q ? 8'd0 : pal_rdata_i[23:16];
      out_data_o.green = pal_oor_q ? 8'd0 : pal_rdata_i[15:8];
      out_data_o.blue = pal_oor_q ? 8'd0 : pal_rdata_i[7:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/bmp_checker.sv */
// Port-level checks for the unpacker and their bind to the top level.
module bmp_checker
  import bmp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input bmp_out_t          out_data_o
);

  // input is held back only by a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // a fresh result needs an item accepted in the previous cycle
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o && out_stall_i)) |->
      $past(in_valid_i && !in_stall_o))
    else $error("result without an accepted item");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind bmp_pixel_to_rgba bmp_checker u_bmp_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench for bmp_pixel_to_rgba: directed table, then random format/size phases.
module tb;
  import bmp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS = 500;
  localparam int DRAIN_CYCLES = 4;
  localparam int GAP_MAX = 17;
  localparam int HOLD_AT = 40;
  localparam int LONG_HOLD = 500;

  // format code with no mode of its own
  localparam logic [1:0] FMT_UNUSED = 2'd3;

  typedef enum logic {ROW_SETTING, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       fmt;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    bmp_in_t          item;
    logic             typed;
    bmp_out_t         want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  bmp_in_t           in_data;
  logic              out_valid;
  logic              out_stall;
  bmp_out_t          out_data;

  always #1 clk = ~clk;

  bmp_pixel_to_rgba dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // predictor state
  logic [23:0]      pal_mem [256];
  bit   [255:0]     pal_written = '0;
  int               pal_idx_q [$];
  logic [1:0]       byte_pos = '0;
  logic [23:0]      held = '0;
  int               col = 0;
  int               frow = 0;
  logic [1:0]       pad_left = '0;
  bit               in_pad = 1'b0;
  logic [1:0]       cur_fmt = FMT_BGR24;
  logic [DIM_W-1:0] cur_w = DIM_W'(1);
  logic [DIM_W-1:0] cur_h = DIM_W'(1);

  bmp_out_t  pixel_q [$];
  stim_row_t dir_rows [$];
  bmp_out_t  mon_want;

  int  n_err = 0;
  int  n_items = 0;
  int  n_palw = 0;
  int  n_cfg = 0;
  int  n_pix = 0;
  int  n_last = 0;
  int  cycles = 0;
  int  snd_count = 0;
  bit  snd_calm = 1'b0;

  task automatic report_mismatch(input string what);
    if (n_err < 50) $display("%0t ns: mismatch: %s", $realtime, what);
    n_err++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("pixel %0d %s got %0h want %0h", n_pix, name, got, want));
  endtask

  // One accepted item through the unpacker; returns 1 when it completes a pixel.
  function automatic bit unpack_byte(input bmp_in_t it, output bmp_out_t px);
    int          w;
    int          h;
    int          bpp;
    int          pad;
    logic [23:0] e;
    bit          row_end;
    bit          img_end;
    px = '0;
    if (it.cmd == CMD_PAL_WRITE) begin
      pal_mem[it.palette_index] = {it.palette_red, it.palette_green, it.palette_blue};
      if (!pal_written[it.palette_index]) begin
        pal_written[it.palette_index] = 1'b1;
        pal_idx_q.push_back(int'(it.palette_index));
      end
      return 1'b0;
    end
    if (in_pad) begin
      pad_left = pad_left - 2'd1;
      if (pad_left == 2'd0) in_pad = 1'b0;
      return 1'b0;
    end
    if (cur_fmt == FMT_PAL8) begin
      e = pal_mem[it.data_byte];
      px.red = e[23:16];
      px.green = e[15:8];
      px.blue = e[7:0];
      px.alpha = ALPHA_OPAQUE;
    end else if (cur_fmt == FMT_BGR24 && byte_pos >= 2'd2) begin
      px.red = it.data_byte;
      px.green = held[15:8];
      px.blue = held[7:0];
      px.alpha = ALPHA_OPAQUE;
    end else if (cur_fmt != FMT_BGR24 && byte_pos == 2'd3) begin
      px.red = held[23:16];
      px.green = held[15:8];
      px.blue = held[7:0];
      px.alpha = it.data_byte;
    end else begin
      held[8*byte_pos +: 8] = it.data_byte;
      byte_pos = byte_pos + 2'd1;
      return 1'b0;
    end
    w = (cur_w == 0) ? 1 : ((cur_w > MAX_DIM) ? MAX_DIM : cur_w);
    h = (cur_h == 0) ? 1 : ((cur_h > MAX_DIM) ? MAX_DIM : cur_h);
    bpp = (cur_fmt == FMT_PAL8) ? 1 : ((cur_fmt == FMT_BGR24) ? 3 : 4);
    row_end = (col >= w - 1);
    img_end = row_end && (frow >= h - 1);
    px.pixel_x = POS_W'(col);
    px.pixel_y = POS_W'(h - 1 - frow);
    px.last_pixel = img_end;
    if (row_end) begin
      pad = (-(w * bpp)) & 3;
      col = 0;
      frow = img_end ? 0 : frow + 1;
      if (pad != 0) begin
        in_pad = 1'b1;
        pad_left = 2'(pad);
      end
    end else begin
      col++;
    end
    byte_pos = '0;
    held = '0;
    return 1'b1;
  endfunction

  function automatic bmp_in_t pix(input logic [7:0] d);
    logic [63:0] rnd;
    bmp_in_t     p;
    rnd = {$urandom, $urandom};
    p = rnd[$bits(bmp_in_t)-1:0];
    p.cmd = CMD_PIXEL;
    p.data_byte = d;
    return p;
  endfunction

  function automatic bmp_in_t palw(input logic [7:0] idx, input logic [7:0] r,
                                   input logic [7:0] g, input logic [7:0] b);
    logic [63:0] rnd;
    bmp_in_t     p;
    rnd = {$urandom, $urandom};
    p = rnd[$bits(bmp_in_t)-1:0];
    p.cmd = CMD_PAL_WRITE;
    p.palette_index = idx;
    p.palette_red = r;
    p.palette_green = g;
    p.palette_blue = b;
    return p;
  endfunction

  function automatic bmp_out_t rgba(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input logic [7:0] a,
                                    input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                    input logic last);
    bmp_out_t o;
    o.red = r;
    o.green = g;
    o.blue = b;
    o.alpha = a;
    o.pixel_x = x;
    o.pixel_y = y;
    o.last_pixel = last;
    return o;
  endfunction

  function automatic void add_cfg(input logic [1:0] f, input logic [DIM_W-1:0] w,
                                  input logic [DIM_W-1:0] h);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SETTING;
    r.fmt = f;
    r.w = w;
    r.h = h;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_item(input bmp_in_t it);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = it;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_checked(input bmp_in_t it, input bmp_out_t want);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = it;
    r.typed = 1'b1;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim(input int top);
    case ($urandom_range(0, 19))
      0: return '0;
      1: return DIM_W'(MAX_DIM);
      2: return '1;
      3: return DIM_W'(MAX_DIM - 1);
      default: return DIM_W'($urandom_range(1, top));
    endcase
  endfunction

  // Registers change only once the block has drained.
  task automatic write_setting(input logic [1:0] f, input logic [DIM_W-1:0] w,
                               input logic [DIM_W-1:0] h);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PIXEL_FORMAT;
    cfg_wdata <= CFG_DW'(f);
    @(posedge clk);
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_fmt = f;
    cur_w = w;
    cur_h = h;
    n_cfg++;
  endtask

  task automatic push_item(input bmp_in_t it, input bit typed, input bmp_out_t want);
    int       gap;
    bmp_out_t px;
    if (snd_count % 40 == 0) snd_calm = ($urandom_range(0, 3) == 0);
    snd_count++;
    gap = snd_calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (unpack_byte(it, px)) pixel_q.push_back(typed ? want : px);
    if (it.cmd == CMD_PAL_WRITE) n_palw++;
    n_items++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still due", cycles, pixel_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("pixel with no expected item");
      end else begin
        mon_want = pixel_q.pop_front();
        check_field("red", 32'(out_data.red), 32'(mon_want.red));
        check_field("green", 32'(out_data.green), 32'(mon_want.green));
        check_field("blue", 32'(out_data.blue), 32'(mon_want.blue));
        check_field("alpha", 32'(out_data.alpha), 32'(mon_want.alpha));
        check_field("pixel_x", 32'(out_data.pixel_x), 32'(mon_want.pixel_x));
        check_field("pixel_y", 32'(out_data.pixel_y), 32'(mon_want.pixel_y));
        check_field("last_pixel", 32'(out_data.last_pixel), 32'(mon_want.last_pixel));
        n_pix++;
        if (mon_want.last_pixel) n_last++;
      end
    end
  end

  // Output side stall, with one long hold-off so the block backs up.
  initial begin
    int wait_n;
    int n_taken;
    bit calm;
    out_stall = 1'b0;
    n_taken = 0;
    calm = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (n_taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      wait_n = (n_taken == HOLD_AT) ? LONG_HOLD : (calm ? 0 : $urandom_range(0, GAP_MAX));
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      n_taken++;
    end
  end

  initial begin
    stim_row_t        row;
    bmp_in_t          it;
    logic [7:0]       d;
    int               len;
    int               n_rand;
    logic [1:0]       f;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    n_rand = 0;

    // reset values: 24-bit, 1 x 1, one pad byte per row
    add_item(pix(8'h00));
    add_item(pix(8'h00));
    add_checked(pix(8'hFF), rgba(8'hFF, 8'h00, 8'h00, ALPHA_OPAQUE, '0, '0, 1'b1));
    add_item(pix(8'hA5));
    add_item(pix(8'hFF));
    add_item(pix(8'hFF));
    add_checked(pix(8'h00), rgba(8'h00, 8'hFF, 8'hFF, ALPHA_OPAQUE, '0, '0, 1'b1));
    add_item(pix(8'h5A));
    // zero width, height above max
    add_cfg(FMT_BGRA32, '0, '1);
    add_item(pix(8'h11));
    add_item(pix(8'h22));
    add_item(pix(8'h33));
    add_checked(pix(8'h44), rgba(8'h33, 8'h22, 8'h11, 8'h44, '0, '1, 1'b0));
    add_item(pix(8'h01));
    add_item(pix(8'h02));
    add_item(pix(8'h03));
    // three bytes held from 32-bit mode, finished in 24-bit mode
    add_cfg(FMT_BGR24, '0, '1);
    add_item(pix(8'h04));
    add_item(pix(8'h00));
    // unused format code, row counter past the new height
    add_cfg(FMT_UNUSED, DIM_W'(MAX_DIM + 1), DIM_W'(1));
    add_item(pix(8'h80));
    add_item(pix(8'h40));
    add_item(pix(8'h20));
    add_item(pix(8'h10));
    add_item(palw(8'h00, 8'hFF, 8'h00, 8'h80));
    add_item(palw(8'hFF, 8'h01, 8'h02, 8'h03));
    add_cfg(FMT_PAL8, DIM_W'(3), DIM_W'(2));
    add_item(pix(8'h00));
    add_item(pix(8'hFF));
    add_item(pix(8'h00));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_SETTING) write_setting(row.fmt, row.w, row.h);
      else push_item(row.item, row.typed, row.want);
    end

    while (n_rand < RAND_ITEMS) begin
      f = 2'($urandom_range(0, 3));
      w = pick_dim(6);
      h = pick_dim(4);
      write_setting(f, w, h);
      len = $urandom_range(20, 60);
      repeat (len) begin
        if ($urandom_range(0, 7) == 0) begin
          it = palw(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          d = 8'($urandom);
          if (!in_pad && cur_fmt == FMT_PAL8)
            d = 8'(pal_idx_q[$urandom_range(0, pal_idx_q.size() - 1)]);
          it = pix(d);
        end
        push_item(it, 1'b0, '0);
        n_rand++;
      end
    end

    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d palette writes) over %0d register settings",
             n_items, n_palw, n_cfg);
    $display("checked %0d pixels, %0d of them image ends; %0d mismatches",
             n_pix, n_last, n_err);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/bmp_pkg.sv
hw/rtl/bmp_cfg_regs.sv
hw/rtl/bmp_palette.sv
hw/rtl/bmp_unpack.sv
hw/rtl/bmp_pixel_to_rgba.sv
hw/rtl/bmp_checker.sv
tb/tb.sv
